// ===== sv/sdpg_pkg.sv =====
`default_nettype none
package sdpg_pkg;

	localparam int unsigned STEP_W   = 32;
	localparam int unsigned RATE_W   = 20;
	localparam int unsigned CAP_W    = 14;
	localparam int unsigned PULSE_W  = 7;
	localparam int unsigned IN_W     = 56;  // step_count, direction, rate_hz, zero fill
	localparam int unsigned OUT_W    = 40;  // six result fields, zero fill
	localparam int unsigned KIND_W   = 3;

	localparam logic [CAP_W-1:0]   MAX_RATE_RESET = CAP_W'(3000);
	localparam logic [RATE_W-1:0]  TICKS_PER_SEC  = RATE_W'(1000000);
	localparam logic [PULSE_W-1:0] PULSE_TICKS    = PULSE_W'(50);

	// restoring divider: one quotient bit per cycle
	localparam int unsigned DIV_BITS  = RATE_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_BITS - 1);

	localparam logic [KIND_W-1:0] KIND_TICK = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RUN  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_JOG  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HOLD = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STOP = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_EXEC,
		ST_RESP
	} sdpg_state_t;

	typedef struct packed {
		logic latch;
		logic div_start;
		logic div_step;
		logic do_tick;
		logic do_hold;
		logic do_stop;
		logic do_begin;
		logic out_load;
	} sdpg_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              cmd_ok;
		logic              div_done;
	} sdpg_stat_t;

endpackage
`default_nettype wire

// ===== sv/sdpg_ctrl.sv =====
`default_nettype none
module sdpg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire sdpg_pkg::sdpg_stat_t stat,
	output sdpg_pkg::sdpg_cmd_t    cmd
);
	import sdpg_pkg::*;

	sdpg_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RESP;
				unique case (stat.kind)
					KIND_TICK: cmd.do_tick = 1'b1;
					KIND_RUN, KIND_JOG: begin
						if (stat.cmd_ok) begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end
					end
					KIND_HOLD: cmd.do_hold = 1'b1;
					KIND_STOP: cmd.do_stop = 1'b1;
					default: ;  // unused kinds answer like a rejected command
				endcase
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.do_begin = 1'b1;
				state_d      = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// a result never overwrites one still waiting to be taken
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transaction");

	// one item at a time: no accept until its result is loaded
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in progress");

	// motion only begins after a divide that was started
	a_begin_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_begin |-> $past(cmd.div_step) && $past(stat.div_done))
		else $error("motion begun without a finished divide");

endmodule
`default_nettype wire

// ===== sv/sdpg_dpath.sv =====
`default_nettype none
module sdpg_dpath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire sdpg_pkg::sdpg_cmd_t                cmd,
	input  wire logic [sdpg_pkg::IN_W-1:0]          in_data,
	input  wire logic [sdpg_pkg::KIND_W-1:0]        in_kind,
	input  wire logic                               cfg_we,
	input  wire logic [sdpg_pkg::CAP_W-1:0]         cfg_wdata,
	output sdpg_pkg::sdpg_stat_t                    stat,
	output logic [sdpg_pkg::OUT_W-1:0]              out_data
);
	import sdpg_pkg::*;

	// latched item
	logic [KIND_W-1:0] kind_q;
	logic [STEP_W-1:0] steps_q;
	logic              dir_in_q;
	logic [RATE_W-1:0] rate_q;

	logic [CAP_W-1:0]  max_rate_q;

	// divider
	logic [CAP_W-1:0]     divisor_q;
	logic [CAP_W-1:0]     rem_q;
	logic [RATE_W-1:0]    dvd_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CAP_W:0]       shifted;
	logic                 ge;
	logic [CAP_W:0]       diff;
	logic [CAP_W-1:0]     cap;
	logic [CAP_W-1:0]     clamped;

	// motion state
	logic               active_q, continuous_q, dir_out_q, led_out_q, ok_q;
	logic [STEP_W-1:0]  remaining_q, done_q;
	logic [RATE_W-1:0]  period_q, until_q;
	logic [PULSE_W-1:0] pulse_q;

	logic [PULSE_W-1:0] pulse_dec;
	logic [STEP_W-1:0]  rem_dec;
	logic [RATE_W-1:0]  quotient;

	assign stat.kind     = kind_q;
	assign stat.cmd_ok   = (rate_q != '0) &&
		((kind_q == KIND_JOG) || ((kind_q == KIND_RUN) && (steps_q != '0)));
	assign stat.div_done = (div_cnt_q == '0);

	assign cap     = (max_rate_q != '0) ? max_rate_q : MAX_RATE_RESET;
	assign clamped = (rate_q > {{(RATE_W-CAP_W){1'b0}}, cap}) ? cap : rate_q[CAP_W-1:0];

	assign shifted = {rem_q, dvd_q[RATE_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};
	assign quotient = (dvd_q == '0) ? RATE_W'(1) : dvd_q;

	assign pulse_dec = (pulse_q != '0) ? pulse_q - PULSE_W'(1) : pulse_q;
	assign rem_dec   = (remaining_q != '0) ? remaining_q - STEP_W'(1) : remaining_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q   <= in_kind;
			steps_q  <= in_data[STEP_W-1:0];
			dir_in_q <= in_data[STEP_W];
			rate_q   <= in_data[STEP_W+RATE_W:STEP_W+1];
		end
		if (cmd.div_start) begin
			divisor_q <= clamped;
			rem_q     <= '0;
			dvd_q     <= TICKS_PER_SEC;
			div_cnt_q <= DIV_LAST;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? diff[CAP_W-1:0] : shifted[CAP_W-1:0];
			dvd_q     <= {dvd_q[RATE_W-2:0], ge};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
		if (cmd.out_load)
			out_data <= {{(OUT_W-STEP_W-5){1'b0}}, ok_q, done_q, active_q,
				led_out_q, dir_out_q, (pulse_q != '0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q   <= MAX_RATE_RESET;
			active_q     <= 1'b0;
			continuous_q <= 1'b0;
			remaining_q  <= '0;
			done_q       <= '0;
			period_q     <= '0;
			until_q      <= '0;
			pulse_q      <= '0;
			dir_out_q    <= 1'b0;
			led_out_q    <= 1'b0;
			ok_q         <= 1'b0;
		end else begin
			if (cfg_we)
				max_rate_q <= cfg_wdata;
			if (cmd.latch) begin
				ok_q <= 1'b0;
			end else if (cmd.do_tick) begin
				pulse_q <= pulse_dec;
				if (active_q) begin
					if (until_q != '0) begin
						until_q <= until_q - RATE_W'(1);
					end else begin
						pulse_q <= PULSE_TICKS;
						until_q <= period_q - RATE_W'(1);
						done_q  <= done_q + STEP_W'(1);
						if (!continuous_q) begin
							remaining_q <= rem_dec;
							if (rem_dec == '0) begin
								active_q  <= 1'b0;
								led_out_q <= 1'b0;
							end
						end
					end
				end
			end else if (cmd.do_hold || cmd.do_stop) begin
				active_q     <= 1'b0;
				continuous_q <= 1'b0;
				remaining_q  <= '0;
				period_q     <= '0;
				until_q      <= '0;
				pulse_q      <= '0;
				dir_out_q    <= cmd.do_hold & dir_in_q;
				led_out_q    <= cmd.do_hold & dir_in_q;
			end else if (cmd.do_begin) begin
				active_q     <= 1'b1;
				continuous_q <= (kind_q == KIND_JOG);
				remaining_q  <= (kind_q == KIND_JOG) ? '0 : steps_q;
				period_q     <= quotient;
				until_q      <= '0;
				pulse_q      <= '0;
				done_q       <= '0;
				dir_out_q    <= dir_in_q;
				led_out_q    <= 1'b1;
				ok_q         <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/step_dir_pulse_generator_unit.sv =====
`default_nettype none
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: step_count, direction, rate_hz; tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: step, dir, led, busy, completed, accepted
// cfg       in   cfg_we                       cfg_wdata: max_rate_hz
//
// One item in flight at a time. Tick, hold, stop and rejected commands go from
// accept through decode to the response state; an accepted run or jog also passes
// through the restoring divider that forms the step period and an execute state.
// arst_n clears all motion state and loads max_rate_hz with 3000.
// A result waiting on m_axis_tready does not block the next accept; the block
// stalls in its response state only when the output register is full and m_axis_tready is low.
module step_dir_pulse_generator_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] step_count, [32] direction, [52:33] rate_hz, [55:53] zero
	input  wire logic [sdpg_pkg::IN_W-1:0]     s_axis_tdata,
	// [2:0] kind
	input  wire logic [sdpg_pkg::KIND_W-1:0]   s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [0] step_level, [1] dir_level, [2] led_level, [3] busy_res,
	// [35:4] completed, [36] accepted, [39:37] zero
	output logic [sdpg_pkg::OUT_W-1:0]         m_axis_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [sdpg_pkg::CAP_W-1:0]    cfg_wdata
);
	import sdpg_pkg::*;

	sdpg_cmd_t  cmd;
	sdpg_stat_t stat;

	sdpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sdpg_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire
